### rtl/mtg_pkg.sv
`timescale 1ns / 1ps

package mtg_pkg;

   // Table geometry
   localparam int unsigned TABLE_WORDS  = 624;
   localparam int unsigned SHIFT_OFFSET = 397;
   localparam int unsigned IDX_W        = $clog2(TABLE_WORDS);
   localparam int unsigned WORD_W       = 32;

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
   localparam logic [IDX_W-1:0] IDX_FAR   = IDX_W'(SHIFT_OFFSET);
   // index at which i + SHIFT_OFFSET wraps round the table
   localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(TABLE_WORDS - SHIFT_OFFSET);

   // Generator constants
   localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

   // Sequencer states of the back end
   typedef enum logic [3:0] {
      ST_SEED   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_TWIST  = 4'b0100,
      ST_TEMPER = 4'b1000
   } mtg_state_type;

   // Back end status seen by the front end
   typedef struct packed {
      logic seeding;
      logic pop;
   } mtg_back_stat_type;

   // One step of the seeding recurrence
   function automatic logic [WORD_W-1:0] seed_next(input logic [WORD_W-1:0] prev,
                                                   input logic [IDX_W-1:0]  k);
      logic [WORD_W-1:0] prod;
      prod = SEED_MULT * (prev ^ (prev >> 30));
      return prod + {{(WORD_W-IDX_W){1'b0}}, k};
   endfunction

   // New table word from t[i], t[i+1] and t[i+397]
   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] upper_src,
                                                    input logic [WORD_W-1:0] lower_src,
                                                    input logic [WORD_W-1:0] far_src);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      y = {upper_src[WORD_W-1], lower_src[WORD_W-2:0]};
      v = far_src ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   // Output tempering
   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = y ^ (y >> 11);
      b = a ^ ((a << 7) & TEMPER_B);
      c = b ^ ((b << 15) & TEMPER_C);
      return c ^ (c >> 18);
   endfunction

endpackage

### rtl/mtg_front.sv
`timescale 1ns / 1ps

module mtg_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] draw, [7:1] zero
   input  mtg_pkg::mtg_back_stat_type back_stat,
   output logic                       pending
);
   import mtg_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             push;

   // Queue of outstanding draw requests; items with draw clear are dropped here
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign req_tready = !full && !back_stat.seeding;
   assign push       = req_tvalid && req_tready && req_tdata[0];
   assign pending    = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !back_stat.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && back_stat.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/mtg_back.sv
`timescale 1ns / 1ps

module mtg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [31:0]                 csr_wdata,
   input  logic                        pending,
   output mtg_pkg::mtg_back_stat_type  back_stat,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata
);
   import mtg_pkg::*;

   // State table, two read ports and one write port
   logic [WORD_W-1:0] table_mem [TABLE_WORDS];

   mtg_state_type     state_ff,    state_in;
   logic [IDX_W-1:0]  k_ff,        k_in;
   logic [IDX_W-1:0]  idx_ff,      idx_in;
   logic [WORD_W-1:0] seed_ff;
   logic [WORD_W-1:0] prev_ff,     prev_in;
   logic [WORD_W-1:0] cur_ff,      cur_in;
   logic [WORD_W-1:0] word_ff,     word_in;
   logic [WORD_W-1:0] rd_next_ff;
   logic [WORD_W-1:0] rd_far_ff;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_data_ff,  out_data_in;

   logic [IDX_W-1:0]  addr_next;
   logic [IDX_W-1:0]  addr_far;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] seed_word;
   logic [WORD_W-1:0] twisted;
   logic              pop;

   // Neighbours of the current index, wrapped round the table
   assign addr_next = (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);
   assign addr_far  = (idx_ff >= IDX_WRAP) ? idx_ff - IDX_WRAP : idx_ff + IDX_FAR;

   assign seed_word = seed_next(prev_ff, k_ff);
   assign twisted   = twist_word(cur_ff, rd_next_ff, rd_far_ff);

   // Sequencer: seeding sweep, then twist and temper one word per draw
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      word_in      = word_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = seed_word;
      pop          = 1'b0;
      case (state_ff)
         ST_SEED: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            if (k_ff == '0) begin
               wr_data = seed_ff;
               prev_in = seed_ff;
               cur_in  = seed_ff;
            end else begin
               wr_data = seed_word;
               prev_in = seed_word;
            end
            if (k_ff == IDX_LAST) begin
               state_in = ST_IDLE;
               k_in     = '0;
               idx_in   = '0;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            // read ports capture t[i+1] and t[i+397] at this edge
            if (pending) begin
               pop      = 1'b1;
               state_in = ST_TWIST;
            end
         end
         ST_TWIST: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = twisted;
            word_in  = twisted;
            cur_in   = rd_next_ff;
            idx_in   = addr_next;
            state_in = ST_TEMPER;
         end
         ST_TEMPER: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = temper(word_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SEED;
            k_in     = '0;
         end
      endcase
      // reseed on a seed write
      if (csr_wen) begin
         state_in = ST_SEED;
         k_in     = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED;
         k_ff         <= '0;
         idx_ff       <= '0;
         seed_ff      <= SEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            seed_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   // Table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_next_ff <= table_mem[addr_next];
      rd_far_ff  <= table_mem[addr_far];
   end

   assign back_stat.seeding = (state_ff == ST_SEED);
   assign back_stat.pop     = pop;
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata         = out_data_ff;

`ifndef SYNTH
   // a request is only taken from the queue when one is waiting
   assert property (@(posedge clock) disable iff (reset) pop |-> pending)
      else $error("pop from empty request queue");
   // twist always follows the cycle that fetched its neighbours
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_TWIST) |-> ($past(state_ff) == ST_IDLE))
      else $error("twist without fetch");
   // read index stays inside the table
   assert property (@(posedge clock) disable iff (reset) idx_ff <= IDX_LAST)
      else $error("read index out of range");
   // a tempered word is never loaded over an unaccepted one
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_TEMPER && out_valid_ff && !rsp_tready)
                    |=> (state_ff == ST_TEMPER || csr_wen))
      else $error("output overwritten while stalled");
`endif

endmodule

### rtl/mt19937_generator_unit.sv
`timescale 1ns / 1ps

// MT19937 random word generator.
// req channel: each item with draw set asks for one 32-bit tempered word;
// an item with draw clear is accepted and dropped without a result.
// rsp channel: one item per draw, in request order.
// csr port: writing csr_wdata with csr_wen high loads a new seed and
// restarts the table fill; write only while no draw is outstanding.
// After reset and after every seed write the 624-word table is filled by
// the seeding recurrence, one word a cycle, and req_tready is low
// throughout the fill. Reset seed is 5489.
// Each draw twists one table word in place and tempers it; the sequencer
// steps through fetch of two neighbours, twist and write-back, and temper
// into the output register, and takes up the next draw only after that.
// With the sequencer idle, an accepted request passes the queue counter
// and the idle, twist and temper states before rsp_tvalid rises.
// Up to QUEUE_DEPTH requests queue in front of the sequencer. A stalled
// receiver holds the output register; the sequencer then waits with one
// twisted word and the queue keeps taking requests until it is full.
module mt19937_generator_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,    // [31:0] seed_value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] draw, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [31:0] random_word
);
   import mtg_pkg::*;

   mtg_back_stat_type back_stat;
   logic              pending;

   mtg_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .back_stat  (back_stat),
      .pending    (pending)
   );

   mtg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .back_stat  (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### bench/mt19937_word_checker.sv
`timescale 1ns / 1ps

// Watches the seed port and both stream channels of the generator, keeps its
// own copy of the twister table and checks every returned word in order.
module mt19937_word_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          mismatches,
   output int          outstanding,
   output int          words_checked
);
   import mtg_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Shadow generator state
   logic [WORD_W-1:0] mt_state [TABLE_WORDS];
   int unsigned       mt_pos;

   // Words owed by the block, oldest first
   logic [WORD_W-1:0] owed_words [$];
   logic [WORD_W-1:0] want_word;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      words_checked = 0;
   end

   // Fill the table from a seed and restart at the first word
   function automatic void mt_reseed(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] prev;
      mt_state[0] = seed;
      for (int unsigned k = 1; k < TABLE_WORDS; k++) begin
         prev       = mt_state[k-1];
         mt_state[k] = SEED_MULT * (prev ^ (prev >> 30)) + k;
      end
      mt_pos = 0;
   endfunction

   // Twist the whole table in place; later words see earlier new ones
   function automatic void mt_twist();
      logic [WORD_W-1:0] mix;
      logic [WORD_W-1:0] fresh;
      for (int unsigned k = 0; k < TABLE_WORDS; k++) begin
         mix   = (mt_state[k] & 32'h8000_0000)
               | (mt_state[(k + 1) % TABLE_WORDS] & 32'h7FFF_FFFF);
         fresh = mt_state[(k + SHIFT_OFFSET) % TABLE_WORDS] ^ (mix >> 1);
         if (mix[0]) begin
            fresh = fresh ^ TWIST_MATRIX;
         end
         mt_state[k] = fresh;
      end
   endfunction

   // Next tempered word; twists first when the index is back at zero
   function automatic logic [WORD_W-1:0] mt_next_word();
      logic [WORD_W-1:0] y;
      if (mt_pos >= TABLE_WORDS) begin
         mt_pos = 0;
      end
      if (mt_pos == 0) begin
         mt_twist();
      end
      y = mt_state[mt_pos];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      mt_pos = (mt_pos + 1) % TABLE_WORDS;
      return y;
   endfunction

   // Sample at the edge: seed writes, returned words, then new draws
   always @(posedge clock) begin
      if (reset) begin
         mt_reseed(SEED_RESET);
         owed_words.delete();
      end else begin
         if (csr_wen) begin
            mt_reseed(csr_wdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: word %h returned with no draw waiting", $realtime, rsp_tdata);
               end
            end else begin
               want_word = owed_words.pop_front();
               words_checked++;
               if (rsp_tdata !== want_word) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: word %0d: expected %h, got %h",
                              $realtime, words_checked, want_word, rsp_tdata);
                  end
               end
            end
         end
         // draw clear: item is swallowed, nothing owed
         if (req_tvalid && req_tready && req_tdata[0]) begin
            owed_words.push_back(mt_next_word());
         end
      end
      outstanding <= owed_words.size();
   end

endmodule

### bench/mt19937_generator_unit_tb.sv
`timescale 1ns / 1ps

module mt19937_generator_unit_tb;

   import mtg_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 32;   // quiet gap before a seed write
   localparam int HOLD_CYCLES  = 120;

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] draw, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] random_word

   int mismatches;
   int outstanding;
   int words_checked;

   // Stimulus bookkeeping
   bit calm;
   int hold_asks;
   int holds_done;
   int seeds_written;
   int swallowed_items;

   mt19937_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mt19937_word_checker word_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #(5_000_000);
      $display("mt19937_generator_unit_tb failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_asks != holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 19);
         end
      end
   end

   // Offer one request item and wait for it to be taken; maybe idle afterwards
   task automatic offer_item(input logic draw_bit);
      req_tdata  <= {7'd0, draw_bit};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (!draw_bit) begin
         swallowed_items++;
      end
      if (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop offering until every owed word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Seed write, only with the block idle
   task automatic write_seed(input logic [31:0] seed);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wdata <= seed;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      seeds_written++;
   endtask

   // One seed and a run of mostly draws; the pressure run adds a calm
   // stretch, a receiver hold-off and a full drain part way through
   task automatic run_phase(input logic [31:0] seed, input int count, input bit pressure);
      write_seed(seed);
      for (int i = 0; i < count; i++) begin
         if (pressure) begin
            if (i == 100) calm = 1'b1;
            if (i == 250) calm = 1'b0;
            if (i == 300) hold_asks++;
            if (i == 450) drain_results();
         end
         offer_item($urandom_range(99) >= 8);
      end
   endtask

   // Main sequence
   initial begin
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = 32'd0;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      calm       = 1'b0;
      hold_asks  = 0;
      holds_done = 0;
      seeds_written   = 0;
      swallowed_items = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset seed, idle requests in between, extreme seeds
      for (int i = 0; i < 10; i++) offer_item(1'b1);
      offer_item(1'b0);
      offer_item(1'b0);
      for (int i = 0; i < 3; i++) offer_item(1'b1);
      write_seed(32'h0000_0000);
      for (int i = 0; i < 4; i++) offer_item(1'b1);
      offer_item(1'b0);
      write_seed(32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) offer_item(1'b1);

      // Random: the long run crosses the table wrap and carries the pressure
      run_phase(32'h8000_0000, 700, 1'b1);
      run_phase($urandom(), 250, 1'b0);
      run_phase(SEED_RESET, 150, 1'b0);
      run_phase(32'h0000_0001, 200, 1'b0);
      run_phase($urandom(), 200, 1'b0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d words over %0d seed writes plus the reset seed;", words_checked,
               seeds_written);
      $display("%0d idle requests swallowed, %0d receiver hold-offs.", swallowed_items,
               holds_done);
      if (mismatches == 0) begin
         $display("mt19937_generator_unit_tb passed");
      end else begin
         $display("mt19937_generator_unit_tb failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mtg_pkg.sv
rtl/mtg_front.sv
rtl/mtg_back.sv
rtl/mt19937_generator_unit.sv
bench/mt19937_word_checker.sv
bench/mt19937_generator_unit_tb.sv
